// File: rtl/greedy_graph_aggregation_unit_defines.svh
// ---------------------------------------------------------------------------
// Greedy graph aggregation unit: assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef GREEDY_GRAPH_AGGREGATION_UNIT_DEFINES_SVH
`define GREEDY_GRAPH_AGGREGATION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define GGAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ggau: check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define GGAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ggau: check failed");

`endif

// File: rtl/ggau_pkg.sv
// ---------------------------------------------------------------------------
// Greedy graph aggregation unit: package
// Sizes, request codes and the types shared by the top level and the engine.
// ---------------------------------------------------------------------------
package ggau_pkg;

    localparam int MAX_ROWS    = 1024;
    localparam int MAX_ENTRIES = 8192;

    localparam int ROW_W  = $clog2(MAX_ROWS);      // row index
    localparam int RCNT_W = ROW_W + 1;             // row count, 0..MAX_ROWS
    localparam int ENT_W  = $clog2(MAX_ENTRIES);   // entry address
    localparam int ECNT_W = ENT_W + 1;             // entry count, 0..MAX_ENTRIES
    localparam int MARK_W = 11;                    // marker / aggregate count
    localparam int OP_W   = 3;

    localparam logic [OP_W-1:0] OP_ENTRY = 3'd0;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd1;
    localparam logic [OP_W-1:0] OP_RUN   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd4;

    typedef struct packed {
        logic              decided;
        logic [MARK_W-1:0] marker;
    } t_mark;

    typedef struct packed {
        logic              start;
        logic              clear;
        logic              ent_we;
        logic [ENT_W-1:0]  ent_addr;
        logic [ROW_W-1:0]  ent_data;
        logic              row_we;
        logic [ROW_W-1:0]  row_addr;
        logic [ECNT_W-1:0] row_end;
        logic              remote;
        logic              rd_en;
        logic [ROW_W-1:0]  rd_addr;
        logic [RCNT_W-1:0] row_count;
    } t_eng_req;

    typedef struct packed {
        logic              busy;
        t_mark             rd_mark;
        logic [MARK_W-1:0] agg;
    } t_eng_rsp;

    typedef enum logic [2:0] {
        E_IDLE,
        E_CLR,
        E_ROW_RD,
        E_ROW_CHK,
        E_NB_RD,
        E_MK_RD,
        E_MK_WR
    } t_eng_state;

endpackage

// File: rtl/ggau_engine.sv
// ---------------------------------------------------------------------------
// Greedy graph aggregation unit: storage and aggregation engine
// Holds the row, neighbor and marker memories and walks the graph on a run.
// ---------------------------------------------------------------------------
module ggau_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ggau_pkg::t_eng_req i_req,
    output ggau_pkg::t_eng_rsp o_rsp
);

    // row info: {remote, row end offset}
    logic [ggau_pkg::ECNT_W:0]   m_info [ggau_pkg::MAX_ROWS];
    logic [ggau_pkg::ROW_W-1:0]  m_nb   [ggau_pkg::MAX_ENTRIES];
    ggau_pkg::t_mark             m_mark [ggau_pkg::MAX_ROWS];

    logic [ggau_pkg::ECNT_W:0]   r_info_q;
    logic [ggau_pkg::ROW_W-1:0]  r_nb_q;
    ggau_pkg::t_mark             r_mark_q;

    ggau_pkg::t_eng_state        r_state, n_state;
    logic [ggau_pkg::RCNT_W-1:0] r_r, n_r;
    logic [ggau_pkg::ECNT_W-1:0] r_start, n_start;
    logic [ggau_pkg::ECNT_W-1:0] r_stop, n_stop;
    logic [ggau_pkg::ECNT_W-1:0] r_e, n_e;
    logic [ggau_pkg::MARK_W-1:0] r_agg, n_agg;
    logic [ggau_pkg::ROW_W-1:0]  r_nb, n_nb;

    logic                        info_re;
    logic                        nb_re;
    logic                        mk_re;
    logic [ggau_pkg::ROW_W-1:0]  mk_ra;
    logic                        mk_we;
    logic [ggau_pkg::ROW_W-1:0]  mk_wa;
    ggau_pkg::t_mark             mk_wd;

    logic [ggau_pkg::ECNT_W-1:0] row_stop;
    logic                        row_remote;
    logic                        nb_in_range;

    assign row_stop    = r_info_q[ggau_pkg::ECNT_W-1:0];
    assign row_remote  = r_info_q[ggau_pkg::ECNT_W];
    assign nb_in_range = {1'b0, r_nb_q} < i_req.row_count;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ggau_pkg::E_IDLE: begin
                if (i_req.start) n_state = ggau_pkg::E_CLR;
            end
            ggau_pkg::E_CLR: begin
                if (r_r == i_req.row_count) n_state = ggau_pkg::E_ROW_RD;
            end
            ggau_pkg::E_ROW_RD: begin
                n_state = (r_r == i_req.row_count) ? ggau_pkg::E_IDLE : ggau_pkg::E_ROW_CHK;
            end
            ggau_pkg::E_ROW_CHK: begin
                if (r_mark_q.decided || (row_stop == r_start && !row_remote))
                    n_state = ggau_pkg::E_ROW_RD;
                else
                    n_state = ggau_pkg::E_NB_RD;
            end
            ggau_pkg::E_NB_RD: begin
                n_state = (r_e == r_stop) ? ggau_pkg::E_ROW_RD : ggau_pkg::E_MK_RD;
            end
            ggau_pkg::E_MK_RD: begin
                n_state = nb_in_range ? ggau_pkg::E_MK_WR : ggau_pkg::E_NB_RD;
            end
            ggau_pkg::E_MK_WR: begin
                n_state = ggau_pkg::E_NB_RD;
            end
            default: n_state = ggau_pkg::E_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_r     = r_r;
        n_start = r_start;
        n_stop  = r_stop;
        n_e     = r_e;
        n_agg   = r_agg;
        n_nb    = r_nb;
        info_re = 1'b0;
        nb_re   = 1'b0;
        mk_re   = 1'b0;
        mk_ra   = r_r[ggau_pkg::ROW_W-1:0];
        mk_we   = 1'b0;
        mk_wa   = r_r[ggau_pkg::ROW_W-1:0];
        mk_wd   = '0;
        unique case (r_state)
            ggau_pkg::E_IDLE: begin
                mk_re = i_req.rd_en;
                mk_ra = i_req.rd_addr;
                if (i_req.start) begin
                    n_r     = '0;
                    n_start = '0;
                    n_agg   = '0;
                end
            end
            ggau_pkg::E_CLR: begin
                // sweep loaded rows back to undecided
                if (r_r != i_req.row_count) begin
                    mk_we = 1'b1;
                    n_r   = r_r + 1'b1;
                end else begin
                    n_r = '0;
                end
            end
            ggau_pkg::E_ROW_RD: begin
                if (r_r != i_req.row_count) begin
                    info_re = 1'b1;
                    mk_re   = 1'b1;
                end
            end
            ggau_pkg::E_ROW_CHK: begin
                n_stop = row_stop;
                n_e    = r_start;
                if (r_mark_q.decided) begin
                    n_start = row_stop;
                    n_r     = r_r + 1'b1;
                end else if (row_stop == r_start && !row_remote) begin
                    // isolated point
                    mk_we         = 1'b1;
                    mk_wd.decided = 1'b1;
                    n_start       = row_stop;
                    n_r           = r_r + 1'b1;
                end else begin
                    n_agg         = r_agg + 1'b1;
                    mk_we         = 1'b1;
                    mk_wd.decided = 1'b1;
                    mk_wd.marker  = r_agg + 1'b1;
                end
            end
            ggau_pkg::E_NB_RD: begin
                if (r_e == r_stop) begin
                    n_start = r_stop;
                    n_r     = r_r + 1'b1;
                end else begin
                    nb_re = 1'b1;
                end
            end
            ggau_pkg::E_MK_RD: begin
                if (nb_in_range) begin
                    mk_re = 1'b1;
                    mk_ra = r_nb_q;
                    n_nb  = r_nb_q;
                end else begin
                    n_e = r_e + 1'b1;
                end
            end
            ggau_pkg::E_MK_WR: begin
                if (!r_mark_q.decided) begin
                    mk_we         = 1'b1;
                    mk_wa         = r_nb;
                    mk_wd.decided = 1'b1;
                    mk_wd.marker  = r_agg;
                end
                n_e = r_e + 1'b1;
            end
            default: begin
                n_r = r_r;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ggau_pkg::E_IDLE;
            r_agg   <= '0;
        end else begin
            r_state <= n_state;
            r_agg   <= i_req.clear ? '0 : n_agg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_start <= n_start;
        r_stop  <= n_stop;
        r_e     <= n_e;
        r_nb    <= n_nb;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.row_we) m_info[i_req.row_addr] <= {i_req.remote, i_req.row_end};
        if (info_re) r_info_q <= m_info[r_r[ggau_pkg::ROW_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ent_we) m_nb[i_req.ent_addr] <= i_req.ent_data;
        if (nb_re) r_nb_q <= m_nb[r_e[ggau_pkg::ENT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) m_mark[mk_wa] <= mk_wd;
        if (mk_re) r_mark_q <= m_mark[mk_ra];
    end

    assign o_rsp.busy    = (r_state != ggau_pkg::E_IDLE);
    assign o_rsp.rd_mark = r_mark_q;
    assign o_rsp.agg     = r_agg;

endmodule

// File: rtl/greedy_graph_aggregation_unit.sv
// ---------------------------------------------------------------------------
// Greedy graph aggregation unit
// Loads a strength graph, forms greedy aggregates and reports row markers.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries requests: neighbor entry, close
//   row, run, read marker, clear. Only a read request produces a result on
//   the output channel (o_valid/i_ready).
//   Entry, close, read and clear requests are taken one per cycle while no
//   run is busy and the read path is not full; a read result passes through
//   the marker memory read, then the output register.
//   A run request blocks the input until the engine is idle again. The
//   engine first clears each loaded row, then reads and checks every row;
//   a row that opens an aggregate also has each of its entries read and
//   checked, and an entry that names a loaded row costs one more write.
//   The order is set by the marker memory's single read port: one row
//   clear per cycle, then a read/check pair per row and per entry.
//   Reset (and the clear request) empties the graph, the aggregate count and
//   the overflow flag; every row reads marker 0 until a run decides it.
//   A stalled receiver holds the result in the output register; one more
//   read can wait behind it before o_ready drops.
// ---------------------------------------------------------------------------
module greedy_graph_aggregation_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ggau_pkg::OP_W-1:0]   i_operation,
    input  logic [ggau_pkg::ROW_W-1:0]  i_index,
    input  logic                        i_has_remote,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ggau_pkg::ROW_W-1:0]  o_row,
    output logic [ggau_pkg::MARK_W-1:0] o_marker,
    output logic [ggau_pkg::MARK_W-1:0] o_aggregate_count,
    output logic                        o_overflow
);

    ggau_pkg::t_eng_req          eng_req;
    ggau_pkg::t_eng_rsp          eng_rsp;

    logic [ggau_pkg::RCNT_W-1:0] r_row_cnt;
    logic [ggau_pkg::ECNT_W-1:0] r_ent_cnt;
    logic                        r_ovf;
    logic [ggau_pkg::RCNT_W-1:0] r_run_rows;

    logic                        r_s1_vld;
    logic [ggau_pkg::ROW_W-1:0]  r_s1_row;
    logic                        r_s1_inr;
    logic [ggau_pkg::MARK_W-1:0] r_s1_agg;
    logic                        r_s1_ovf;

    logic                        r_out_vld;
    logic [ggau_pkg::ROW_W-1:0]  r_out_row;
    logic [ggau_pkg::MARK_W-1:0] r_out_marker;
    logic [ggau_pkg::MARK_W-1:0] r_out_agg;
    logic                        r_out_ovf;

    logic s1_go;
    logic acc;
    logic is_entry, is_close, is_run, is_read, is_clear;
    logic ent_ok, row_ok;

    assign s1_go   = !r_out_vld || i_ready;
    assign o_ready = i_rst_n && !eng_rsp.busy && (!r_s1_vld || s1_go);
    assign acc     = i_valid && o_ready;

    assign is_entry = acc && (i_operation == ggau_pkg::OP_ENTRY);
    assign is_close = acc && (i_operation == ggau_pkg::OP_CLOSE);
    assign is_run   = acc && (i_operation == ggau_pkg::OP_RUN);
    assign is_read  = acc && (i_operation == ggau_pkg::OP_READ);
    assign is_clear = acc && (i_operation == ggau_pkg::OP_CLEAR);

    assign row_ok = r_row_cnt < ggau_pkg::RCNT_W'(ggau_pkg::MAX_ROWS);
    assign ent_ok = row_ok && (r_ent_cnt < ggau_pkg::ECNT_W'(ggau_pkg::MAX_ENTRIES));

    always_comb begin
        eng_req.start     = is_run;
        eng_req.clear     = is_clear;
        eng_req.ent_we    = is_entry && ent_ok;
        eng_req.ent_addr  = r_ent_cnt[ggau_pkg::ENT_W-1:0];
        eng_req.ent_data  = i_index;
        eng_req.row_we    = is_close && row_ok;
        eng_req.row_addr  = r_row_cnt[ggau_pkg::ROW_W-1:0];
        eng_req.row_end   = r_ent_cnt;
        eng_req.remote    = i_has_remote;
        eng_req.rd_en     = is_read;
        eng_req.rd_addr   = i_index;
        eng_req.row_count = r_row_cnt;
    end

    ggau_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (eng_req),
        .o_rsp   (eng_rsp)
    );

    // graph bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || is_clear) begin
            r_row_cnt  <= '0;
            r_ent_cnt  <= '0;
            r_ovf      <= 1'b0;
            r_run_rows <= '0;
        end else begin
            if (is_entry) begin
                if (ent_ok) r_ent_cnt <= r_ent_cnt + 1'b1;
                else        r_ovf     <= 1'b1;
            end
            if (is_close) begin
                if (row_ok) r_row_cnt <= r_row_cnt + 1'b1;
                else        r_ovf     <= 1'b1;
            end
            // rows at or above this were not swept by the last run
            if (is_run) r_run_rows <= r_row_cnt;
        end
    end

    // read pipeline: s1 waits on the marker memory, then the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (is_read)    r_s1_vld <= 1'b1;
            else if (s1_go) r_s1_vld <= 1'b0;
            if (s1_go)      r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_s1_row <= i_index;
            r_s1_inr <= {1'b0, i_index} < r_run_rows;
            r_s1_agg <= eng_rsp.agg;
            r_s1_ovf <= r_ovf || (is_entry && !ent_ok);
        end
        if (s1_go && r_s1_vld) begin
            r_out_row    <= r_s1_row;
            r_out_marker <= r_s1_inr ? eng_rsp.rd_mark.marker : '0;
            r_out_agg    <= r_s1_agg;
            r_out_ovf    <= r_s1_ovf;
        end
    end

    assign o_valid           = r_out_vld;
    assign o_row             = r_out_row;
    assign o_marker          = r_out_marker;
    assign o_aggregate_count = r_out_agg;
    assign o_overflow        = r_out_ovf;

endmodule

// File: rtl/ggau_checker.sv
// ---------------------------------------------------------------------------
// Greedy graph aggregation unit: port checker
// Watches the top-level ports; bound to the top level below.
// ---------------------------------------------------------------------------
`include "greedy_graph_aggregation_unit_defines.svh"

module ggau_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [ggau_pkg::OP_W-1:0]   i_operation,
    input logic [ggau_pkg::ROW_W-1:0]  i_index,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [ggau_pkg::ROW_W-1:0]  o_row,
    input logic [ggau_pkg::MARK_W-1:0] o_marker,
    input logic [ggau_pkg::MARK_W-1:0] o_aggregate_count,
    input logic                        o_overflow
);

    logic rd_acc;
    logic run_acc;

    assign rd_acc  = i_valid && o_ready && (i_operation == ggau_pkg::OP_READ);
    assign run_acc = i_valid && o_ready && (i_operation == ggau_pkg::OP_RUN);

    // a held result does not move
    `GGAU_ASSERT_NXT(a_out_hold, o_valid && !i_ready,
        o_valid && $stable(o_row) && $stable(o_marker)
        && $stable(o_aggregate_count) && $stable(o_overflow))

    // a fresh result comes from an accepted read of that row
    `GGAU_ASSERT_IMP(a_out_src, $rose(o_valid),
        $past(rd_acc, 2) && (o_row == $past(i_index, 2)))

    // a marker never exceeds the count of aggregates formed
    `GGAU_ASSERT_IMP(a_mark_le_cnt, o_valid, o_marker <= o_aggregate_count)

    // a run holds off new requests while it walks the graph
    `GGAU_ASSERT_NXT(a_run_busy, run_acc, !o_ready)

endmodule

bind greedy_graph_aggregation_unit ggau_checker u_ggau_checker (.*);
